@@ hdl/pld_pkg.sv @@
package pld_pkg;

   localparam int TRIG_ITERATIONS = 16;
   localparam int CORDIC_STEPS = (TRIG_ITERATIONS < 24) ? TRIG_ITERATIONS : 24;
   localparam int STEP_W = 5;
   localparam int ANGLE_W = 25;
   localparam int PITCH_W = 24;
   localparam int Z_W = 26;
   localparam int TRIG_W = 32;
   localparam int MOD_W = 34;
   localparam int PROD_W = 64;
   localparam int SUM_W = 36;
   localparam int MOD_STEPS = 9;

   localparam longint DEG_ONE = 65536;
   localparam longint DEG_90 = 90 * DEG_ONE;
   localparam longint DEG_180 = 180 * DEG_ONE;
   localparam longint DEG_360 = 360 * DEG_ONE;
   localparam longint MOD_BIAS = 256 * DEG_360;
   localparam longint CORDIC_GAIN = 652032874;
   localparam longint OUT_MAX = 16384;

   localparam logic [15:0] SENSITIVITY_RESET = 16'd6554;
   localparam logic [22:0] PITCH_LIMIT_RESET = 23'd5832704;

   typedef enum logic {
      CSR_SENSITIVITY = 1'b0,
      CSR_PITCH_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [10:0] {
      S_IDLE       = 11'b000_0000_0001,
      S_MUL_YAW    = 11'b000_0000_0010,
      S_MUL_PITCH  = 11'b000_0000_0100,
      S_PITCH      = 11'b000_0000_1000,
      S_MOD        = 11'b000_0001_0000,
      S_FOLD       = 11'b000_0010_0000,
      S_CORD_YAW   = 11'b000_0100_0000,
      S_CORD_PITCH = 11'b000_1000_0000,
      S_MUL_X      = 11'b001_0000_0000,
      S_MUL_Z      = 11'b010_0000_0000,
      S_DONE       = 11'b100_0000_0000
   } state_type;

   // Arctangent of 2^-i in Q16.16 degrees.
   function automatic logic [21:0] atan_deg(input logic [STEP_W-1:0] idx);
      logic [21:0] v;
      begin
         case (idx)
            5'd0: v = 22'd2949120;
            5'd1: v = 22'd1740967;
            5'd2: v = 22'd919879;
            5'd3: v = 22'd466945;
            5'd4: v = 22'd234379;
            5'd5: v = 22'd117304;
            5'd6: v = 22'd58666;
            5'd7: v = 22'd29335;
            5'd8: v = 22'd14668;
            5'd9: v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
         endcase
         return v;
      end
   endfunction

endpackage

@@ hdl/pointer_look_direction_top.sv @@
// The time from an accepted transaction to its valid result is dominated by the 9-step
// modulo and the two CORDIC passes.
// A new transaction is not accepted until the last one is done, as the single shared
// CORDIC unit and multiplier serve every step; one item is in flight at a time.
// Reset is synchronous and active high; it restores the default registers, a yaw of -90
// degrees, zero pitch and the first-sample flag.
module pointer_look_direction_top import pld_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_pointer_x,
   input  logic signed [15:0] req_pointer_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_dir_x,
   output logic signed [15:0] rsp_dir_y,
   output logic signed [15:0] rsp_dir_z,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   state_type                  state_ff, state_in;
   logic [15:0]                sensitivity_ff, sensitivity_in;
   logic [22:0]                pitch_limit_ff, pitch_limit_in;
   logic                       first_ff, first_in;
   logic signed [15:0]         last_x_ff, last_x_in;
   logic signed [15:0]         last_y_ff, last_y_in;
   logic signed [ANGLE_W-1:0]  yaw_ff, yaw_in;
   logic signed [PITCH_W-1:0]  pitch_ff, pitch_in;
   logic signed [16:0]         dx_ff, dx_in;
   logic signed [16:0]         dy_ff, dy_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [MOD_W-1:0]           mod_ff, mod_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       neg_cos_ff, neg_cos_in;
   logic signed [TRIG_W-1:0]   x_ff, x_in;
   logic signed [TRIG_W-1:0]   y_ff, y_in;
   logic signed [Z_W-1:0]      z_ff, z_in;
   logic signed [TRIG_W-1:0]   cos_yaw_ff, cos_yaw_in;
   logic signed [TRIG_W-1:0]   sin_yaw_ff, sin_yaw_in;
   logic signed [15:0]         res_x_ff, res_x_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]         rsp_dir_x_ff, rsp_dir_x_in;
   logic signed [15:0]         rsp_dir_y_ff, rsp_dir_y_in;
   logic signed [15:0]         rsp_dir_z_ff, rsp_dir_z_in;

   logic                       csr_write;
   logic signed [TRIG_W-1:0]   mul_a;
   logic signed [TRIG_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]   mul_p;
   logic signed [TRIG_W-1:0]   xs;
   logic signed [TRIG_W-1:0]   ys;
   logic signed [TRIG_W-1:0]   x_step;
   logic signed [TRIG_W-1:0]   y_step;
   logic signed [Z_W-1:0]      z_step;
   logic signed [Z_W-1:0]      atan_ext;
   logic                       last_step;
   logic signed [SUM_W-1:0]    yaw_sum;
   logic signed [SUM_W-1:0]    pitch_sum;
   logic signed [SUM_W-1:0]    lim_s;
   logic [22:0]                lim;
   logic signed [PITCH_W-1:0]  pitch_new;
   logic [STEP_W-1:0]          mod_shamt;
   logic [MOD_W-1:0]           mod_sub;
   logic signed [ANGLE_W-1:0]  yaw_new;
   logic signed [ANGLE_W-1:0]  fold_angle;
   logic                       fold_neg;

   function automatic logic signed [15:0] round_prod(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      begin
         t = (p + (PROD_W'(1) <<< 45)) >>> 46;
         if (t > PROD_W'(OUT_MAX)) begin
            return 16'(OUT_MAX);
         end else if (t < PROD_W'(-OUT_MAX)) begin
            return 16'(-OUT_MAX);
         end
         return 16'(t);
      end
   endfunction

   function automatic logic signed [15:0] round_sin(input logic signed [TRIG_W-1:0] s);
      logic signed [TRIG_W:0] t;
      begin
         t = ((TRIG_W + 1)'(s) + (TRIG_W + 1)'(32768)) >>> 16;
         if (t > (TRIG_W + 1)'(OUT_MAX)) begin
            return 16'(OUT_MAX);
         end else if (t < (TRIG_W + 1)'(-OUT_MAX)) begin
            return 16'(-OUT_MAX);
         end
         return 16'(t);
      end
   endfunction

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_dir_x  = rsp_dir_x_ff;
   assign rsp_dir_y  = rsp_dir_y_ff;
   assign rsp_dir_z  = rsp_dir_z_ff;

   always_comb begin
      unique case (csr_index_type'(csr_paddr[2]))
         CSR_SENSITIVITY: csr_prdata = {16'd0, sensitivity_ff};
         CSR_PITCH_LIMIT: csr_prdata = {9'd0, pitch_limit_ff};
      endcase
   end

   // Shared multiplier operand selection.
   always_comb begin
      unique case (state_ff)
         S_MUL_YAW: begin
            mul_a = TRIG_W'(dx_ff);
            mul_b = $signed(TRIG_W'(sensitivity_ff));
         end
         S_MUL_PITCH: begin
            mul_a = TRIG_W'(dy_ff);
            mul_b = $signed(TRIG_W'(sensitivity_ff));
         end
         S_MUL_X: begin
            mul_a = cos_yaw_ff;
            mul_b = x_ff;
         end
         S_MUL_Z, S_DONE: begin
            mul_a = sin_yaw_ff;
            mul_b = x_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Shared CORDIC rotation step.
   assign xs        = x_ff >>> step_ff;
   assign ys        = y_ff >>> step_ff;
   assign atan_ext  = $signed(Z_W'(atan_deg(step_ff)));
   assign x_step    = z_ff[Z_W-1] ? (x_ff + ys) : (x_ff - ys);
   assign y_step    = z_ff[Z_W-1] ? (y_ff - xs) : (y_ff + xs);
   assign z_step    = z_ff[Z_W-1] ? (z_ff + atan_ext) : (z_ff - atan_ext);
   assign last_step = (step_ff == STEP_W'(CORDIC_STEPS - 1));

   // Yaw offset biased to a positive value that a modulo by 360 degrees leaves equivalent.
   assign yaw_sum = SUM_W'(yaw_ff) + SUM_W'($signed(prod_ff[MOD_W-1:0]))
                  + SUM_W'(DEG_180 + MOD_BIAS);
   assign mod_shamt = STEP_W'(MOD_STEPS - 1) - step_ff;
   assign mod_sub   = MOD_W'(DEG_360) << mod_shamt;
   assign yaw_new   = $signed(mod_ff[ANGLE_W-1:0]) - ANGLE_W'(DEG_180);

   assign pitch_sum = SUM_W'(pitch_ff) + SUM_W'($signed(prod_ff[MOD_W-1:0]));
   assign lim       = (pitch_limit_ff > 23'(DEG_90)) ? 23'(DEG_90) : pitch_limit_ff;
   assign lim_s     = $signed(SUM_W'(lim));

   always_comb begin
      priority if (pitch_sum > lim_s) begin
         pitch_new = PITCH_W'(lim_s);
      end else if (pitch_sum < -lim_s) begin
         pitch_new = PITCH_W'(-lim_s);
      end else begin
         pitch_new = PITCH_W'(pitch_sum);
      end
   end

   always_comb begin
      priority if (yaw_new > ANGLE_W'(DEG_90)) begin
         fold_angle = ANGLE_W'(DEG_180) - yaw_new;
         fold_neg   = 1'b1;
      end else if (yaw_new < ANGLE_W'(-DEG_90)) begin
         fold_angle = ANGLE_W'(-DEG_180) - yaw_new;
         fold_neg   = 1'b1;
      end else begin
         fold_angle = yaw_new;
         fold_neg   = 1'b0;
      end
   end

   always_comb begin
      state_in       = state_ff;
      sensitivity_in = sensitivity_ff;
      pitch_limit_in = pitch_limit_ff;
      first_in       = first_ff;
      last_x_in      = last_x_ff;
      last_y_in      = last_y_ff;
      yaw_in         = yaw_ff;
      pitch_in       = pitch_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      prod_in        = mul_p;
      mod_in         = mod_ff;
      step_in        = step_ff;
      neg_cos_in     = neg_cos_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      cos_yaw_in     = cos_yaw_ff;
      sin_yaw_in     = sin_yaw_ff;
      res_x_in       = res_x_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_dir_x_in   = rsp_dir_x_ff;
      rsp_dir_y_in   = rsp_dir_y_ff;
      rsp_dir_z_in   = rsp_dir_z_ff;

      if (csr_write) begin
         unique case (csr_index_type'(csr_paddr[2]))
            CSR_SENSITIVITY: sensitivity_in = csr_pwdata[15:0];
            CSR_PITCH_LIMIT: pitch_limit_in = csr_pwdata[22:0];
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (first_ff) begin
                  dx_in = '0;
                  dy_in = '0;
               end else begin
                  dx_in = 17'(req_pointer_x) - 17'(last_x_ff);
                  dy_in = 17'(last_y_ff) - 17'(req_pointer_y);
               end
               first_in  = 1'b0;
               last_x_in = req_pointer_x;
               last_y_in = req_pointer_y;
               state_in  = S_MUL_YAW;
            end
         end
         S_MUL_YAW: begin
            state_in = S_MUL_PITCH;
         end
         S_MUL_PITCH: begin
            mod_in   = MOD_W'(yaw_sum);
            state_in = S_PITCH;
         end
         S_PITCH: begin
            pitch_in = pitch_new;
            step_in  = '0;
            state_in = S_MOD;
         end
         S_MOD: begin
            if (mod_ff >= mod_sub) begin
               mod_in = mod_ff - mod_sub;
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(MOD_STEPS - 1)) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            yaw_in   = yaw_new;
            state_in = S_CORD_YAW;
         end
         S_CORD_YAW: begin
            x_in    = x_step;
            y_in    = y_step;
            z_in    = z_step;
            step_in = step_ff + STEP_W'(1);
            if (last_step) begin
               cos_yaw_in = neg_cos_ff ? -x_step : x_step;
               sin_yaw_in = y_step;
               x_in       = TRIG_W'(CORDIC_GAIN);
               y_in       = '0;
               z_in       = Z_W'(pitch_ff);
               step_in    = '0;
               state_in   = S_CORD_PITCH;
            end
         end
         S_CORD_PITCH: begin
            x_in    = x_step;
            y_in    = y_step;
            z_in    = z_step;
            step_in = step_ff + STEP_W'(1);
            if (last_step) begin
               state_in = S_MUL_X;
            end
         end
         S_MUL_X: begin
            state_in = S_MUL_Z;
         end
         S_MUL_Z: begin
            res_x_in = round_prod(prod_ff);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_dir_x_in = res_x_ff;
               rsp_dir_y_in = round_sin(y_ff);
               rsp_dir_z_in = round_prod(prod_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The fold result loads the CORDIC for the yaw pass.
      if (state_ff == S_FOLD) begin
         neg_cos_in = fold_neg;
         x_in       = TRIG_W'(CORDIC_GAIN);
         y_in       = '0;
         z_in       = Z_W'(fold_angle);
         step_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         sensitivity_ff <= SENSITIVITY_RESET;
         pitch_limit_ff <= PITCH_LIMIT_RESET;
         first_ff       <= 1'b1;
         last_x_ff      <= '0;
         last_y_ff      <= '0;
         yaw_ff         <= ANGLE_W'(-DEG_90);
         pitch_ff       <= '0;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sensitivity_ff <= sensitivity_in;
         pitch_limit_ff <= pitch_limit_in;
         first_ff       <= first_in;
         last_x_ff      <= last_x_in;
         last_y_ff      <= last_y_in;
         yaw_ff         <= yaw_in;
         pitch_ff       <= pitch_in;
         step_ff        <= step_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      prod_ff      <= prod_in;
      mod_ff       <= mod_in;
      neg_cos_ff   <= neg_cos_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      cos_yaw_ff   <= cos_yaw_in;
      sin_yaw_ff   <= sin_yaw_in;
      res_x_ff     <= res_x_in;
      rsp_dir_x_ff <= rsp_dir_x_in;
      rsp_dir_y_ff <= rsp_dir_y_in;
      rsp_dir_z_ff <= rsp_dir_z_in;
   end

endmodule
